// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== rtl/pdb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdb_pkg;

  localparam int unsigned PotW    = 10;
  localparam int unsigned PwmW    = 8;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned PeriodW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgIdxLongPress  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxShortMin   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxFloor      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxStep       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxCeiling    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxPwmInterval = 3'd5;

  // Reset values
  localparam logic [TimerW-1:0]  LongPressRst   = 16'd3000;
  localparam logic [TimerW-1:0]  ShortMinRst    = 16'd100;
  localparam logic [PeriodW-1:0] FloorRst       = 12'd150;
  localparam logic [PeriodW-1:0] StepRst        = 12'd200;
  localparam logic [PeriodW-1:0] CeilingRst     = 12'd1000;
  localparam logic [TimerW-1:0]  PwmIntervalRst = 16'd200;

  localparam logic [TimerW-1:0]  TimerMax = '1;

  typedef struct packed {
    logic [TimerW-1:0]  long_press_ms;
    logic [TimerW-1:0]  short_min_ms;
    logic [PeriodW-1:0] period_floor_ms;
    logic [PeriodW-1:0] period_step_ms;
    logic [PeriodW-1:0] period_ceiling_ms;
    logic [TimerW-1:0]  pwm_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic            button_pressed;
    logic [PotW-1:0] pot_sample;
  } in_beat_t;

  // Input register to core
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } in_stage_t;

endpackage

`default_nettype wire

// ===== rtl/pdb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdb_in_if;
  import pdb_pkg::*;

  logic            valid;
  logic            ready;
  logic            button_pressed;
  logic [PotW-1:0] pot_sample;

  modport source (output valid, button_pressed, pot_sample, input ready);
  modport sink   (input valid, button_pressed, pot_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/pdb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdb_out_if;
  import pdb_pkg::*;

  logic               valid;
  logic               ready;
  logic               led_on;
  logic [PwmW-1:0]    pwm_level;
  logic               short_press;
  logic               long_press;
  logic [PeriodW-1:0] blink_period_ms;

  modport source (output valid, led_on, pwm_level, short_press, long_press,
                  blink_period_ms, input ready);
  modport sink   (input valid, led_on, pwm_level, short_press, long_press,
                  blink_period_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/pdb_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdb_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pdb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pdb_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output pdb_pkg::cfg_t                        cfg_o
);
  import pdb_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxLongPress:   cfg_d.long_press_ms     = cfg_wdata_i[TimerW-1:0];
        CfgIdxShortMin:    cfg_d.short_min_ms      = cfg_wdata_i[TimerW-1:0];
        CfgIdxFloor:       cfg_d.period_floor_ms   = cfg_wdata_i[PeriodW-1:0];
        CfgIdxStep:        cfg_d.period_step_ms    = cfg_wdata_i[PeriodW-1:0];
        CfgIdxCeiling:     cfg_d.period_ceiling_ms = cfg_wdata_i[PeriodW-1:0];
        CfgIdxPwmInterval: cfg_d.pwm_interval_ms   = cfg_wdata_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms     <= LongPressRst;
      cfg_q.short_min_ms      <= ShortMinRst;
      cfg_q.period_floor_ms   <= FloorRst;
      cfg_q.period_step_ms    <= StepRst;
      cfg_q.period_ceiling_ms <= CeilingRst;
      cfg_q.pwm_interval_ms   <= PwmIntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/pdb_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdb_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pdb_in_if.sink             in_ch,
  input  wire logic          take_i,
  output pdb_pkg::in_stage_t stage_o
);
  import pdb_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q, beat_d;
  logic     load;

  // Slot is free when empty or being drained this cycle
  assign in_ch.ready = !valid_q || take_i;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (load) begin
      valid_d             = 1'b1;
      beat_d.button_pressed = in_ch.button_pressed;
      beat_d.pot_sample     = in_ch.pot_sample;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;

endmodule

`default_nettype wire

// ===== rtl/pdb_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdb_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pdb_pkg::cfg_t      cfg_i,
  input  wire pdb_pkg::in_stage_t stage_i,
  output logic               take_o,
  pdb_out_if.source          out_ch
);
  import pdb_pkg::*;

  // Tick state
  logic               prev_q, prev_d;
  logic               long_done_q, long_done_d;
  logic               led_q, led_d;
  logic [TimerW-1:0]  press_q, press_d;
  logic [TimerW-1:0]  blink_q, blink_d;
  logic [TimerW-1:0]  pwm_t_q, pwm_t_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [PwmW-1:0]    held_q, held_d;

  // Result register
  logic out_valid_q, out_valid_d;
  logic short_q, short_d;
  logic long_q, long_d;

  logic               pressed;
  logic               press_edge;
  logic               release_edge;
  logic               long_fire;
  logic [PeriodW:0]   period_sum;
  logic [PotW+PwmW-1:0] scaled_prod;
  logic [PwmW-1:0]    scaled_q0;
  logic [PotW:0]      scaled_rem;
  logic [PwmW-1:0]    scaled;

  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] t);
    sat_inc = (t == TimerMax) ? t : t + 1'b1;
  endfunction

  assign take_o  = stage_i.valid && (!out_valid_q || out_ch.ready);
  assign pressed = stage_i.beat.button_pressed;

  // Sample * 255 / 1023: estimate by >>10, one correction step
  assign scaled_prod = ({8'd0, stage_i.beat.pot_sample} << 8)
                     - {8'd0, stage_i.beat.pot_sample};
  assign scaled_q0   = scaled_prod[PotW+PwmW-1:PotW];
  assign scaled_rem  = {1'b0, scaled_prod[PotW-1:0]} + {3'd0, scaled_q0};
  assign scaled      = scaled_q0 + PwmW'(scaled_rem >= 11'd1023);

  assign press_edge   = pressed && !prev_q;
  assign release_edge = !pressed && prev_q;
  assign period_sum   = {1'b0, period_q} + {1'b0, cfg_i.period_step_ms};

  // One tick of the controller
  always_comb begin
    prev_d      = prev_q;
    long_done_d = long_done_q;
    led_d       = led_q;
    press_d     = press_q;
    blink_d     = blink_q;
    pwm_t_d     = pwm_t_q;
    period_d    = period_q;
    held_d      = held_q;
    short_d     = short_q;
    long_d      = long_q;
    long_fire   = 1'b0;
    out_valid_d = out_valid_q;

    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    if (take_o) begin
      out_valid_d = 1'b1;
      short_d     = 1'b0;
      long_d      = 1'b0;
      press_d     = sat_inc(press_q);
      blink_d     = sat_inc(blink_q);
      pwm_t_d     = sat_inc(pwm_t_q);

      if (press_edge) begin
        press_d     = '0;
        long_done_d = 1'b0;
        led_d       = 1'b1;
        blink_d     = '0;
      end

      long_fire = pressed && !long_done_d && (press_d >= cfg_i.long_press_ms);
      if (long_fire) begin
        period_d    = (period_sum > {1'b0, cfg_i.period_ceiling_ms})
                    ? cfg_i.period_floor_ms : period_sum[PeriodW-1:0];
        long_done_d = 1'b1;
        blink_d     = '0;
        long_d      = 1'b1;
      end

      if (release_edge) begin
        short_d = !long_done_d && (press_d >= cfg_i.short_min_ms);
        blink_d = '0;
      end

      // Blink toggle while released
      if (!pressed && (blink_d >= {4'd0, period_d})) begin
        blink_d = '0;
        led_d   = !led_d;
      end

      prev_d = pressed;

      if (pwm_t_d >= cfg_i.pwm_interval_ms) begin
        pwm_t_d = '0;
        held_d  = scaled;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      long_done_q <= 1'b0;
      led_q       <= 1'b0;
      press_q     <= '0;
      blink_q     <= '0;
      pwm_t_q     <= '0;
      period_q    <= FloorRst;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      long_done_q <= long_done_d;
      led_q       <= led_d;
      press_q     <= press_d;
      blink_q     <= blink_d;
      pwm_t_q     <= pwm_t_d;
      period_q    <= period_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pulse fields, no reset
  always_ff @(posedge clk_i) begin
    short_q <= short_d;
    long_q  <= long_d;
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.led_on          = led_q;
  assign out_ch.pwm_level       = held_q;
  assign out_ch.short_press     = short_q;
  assign out_ch.long_press      = long_q;
  assign out_ch.blink_period_ms = period_q;

  `ASSERT_NEVER(a_pulses_exclusive, clk_i, rst_ni, out_valid_q && short_q && long_q, "short and long pulse together")
  `ASSERT_CLK(a_edge_lights_led, clk_i, rst_ni, take_o && press_edge |=> led_q, "press edge did not light LED")
  `ASSERT_CLK(a_long_while_held, clk_i, rst_ni, out_valid_q && long_q |-> prev_q, "long pulse on released tick")
  `ASSERT_CLK(a_short_on_release, clk_i, rst_ni, out_valid_q && short_q |-> !prev_q && !long_done_q, "short pulse while held or after long press")

endmodule

`default_nettype wire

// ===== rtl/press_duration_blink_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Press-duration blink controller.
// in_ch carries one beat per millisecond tick: the button level and a 10-bit
// potentiometer sample. out_ch returns exactly one beat per input beat: LED
// level, held PWM level, short/long press pulses and the blink period in use.
// Config write port cfg_we_i/cfg_idx_i/cfg_wdata_i: the user must write while
// the block is idle (not enforced); indexes past the last register are dropped.
// A beat accepted on in_ch is parked in the input register; the tick update
// writes its result into the output register, where it waits for out_ch.
// Throughput: one beat per cycle while out_ch does not stall, set by the single
// tick update between the input register and the output register.
// Reset clears the timers, press/LED state and PWM level, loads the period
// with 150 and the registers with their defaults; no beat is then pending.
// When the receiver stalls, the result beat holds and one more input beat is
// parked in the input register; after that in_ch.ready drops.

module press_duration_blink_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  pdb_in_if.sink                             in_ch,
  pdb_out_if.source                          out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic [pdb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pdb_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pdb_pkg::*;

  cfg_t      cfg;
  in_stage_t stage;
  logic      take;

  pdb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pdb_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .take_i  (take),
    .stage_o (stage)
  );

  pdb_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .stage_i (stage),
    .take_o  (take),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
